@@ sv/lip_pkg.sv @@
// Package: shared types and constants for the linear interpolation upsampler.
`timescale 1ns / 1ps

package lip_pkg;

    localparam int SAMPLE_W = 16;

    // Rate-mode register codes
    typedef enum logic [1:0] {
        RATE_X1 = 2'd0,
        RATE_X2 = 2'd1,
        RATE_X4 = 2'd2
    } rate_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Result index within one input beat (0 to 7; up to 8 results) and factor count
    typedef logic [2:0] res_idx_t;
    typedef logic [2:0] fac_cnt_t;

endpackage

@@ sv/lip_if.sv @@
// Interfaces: input and result channels of the upsampler.
`timescale 1ns / 1ps

interface lip_in_if
    import lip_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample_in;
    logic    frame_end;

    modport source (output valid, output sample_in, output frame_end, input ready);
    modport sink   (input valid, input sample_in, input frame_end, output ready);
endinterface

interface lip_out_if
    import lip_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample_out;
    logic    run_last;
    logic    frame_done;

    modport source (output valid, output sample_out, output run_last, output frame_done,
                    input ready);
    modport sink   (input valid, input sample_out, input run_last, input frame_done,
                    output ready);
endinterface

@@ sv/linear_interp_upsampler.sv @@
// Top level: linear interpolation upsampler (x1, x2, x4) for framed 16-bit samples.
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    sample_in[15:0] signed, frame_end
//  out_ch    out  valid/ready    sample_out[15:0] signed, run_last, frame_done
//  cfg       in   cfg_we         cfg_wdata[1:0] -> rate_mode
//
// Each accepted beat is expanded in a job register and its results leave one per
// cycle through the output register while out_ch does not stall; a beat has 0 to 8
// results (4 in steady x4). A beat that yields no result leaves the job empty.
// The next beat is taken in the cycle the last result of the current one loads.
// rst_n asynchronously clears the rate mode and the held, job and output valid flags.
// A stall on out_ch holds the output register and back-pressures in_ch.
`timescale 1ns / 1ps

module linear_interp_upsampler
    import lip_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    lip_in_if.sink     in_ch,
    lip_out_if.source  out_ch
);

    // Configuration and held sample
    logic [1:0] rate_mode_reg;
    logic       held_valid_reg;
    sample_t    held_sample_reg;

    // Job register: one input beat being expanded
    logic       job_valid_reg;
    res_idx_t   idx_reg;
    res_idx_t   cnt_last_reg;
    fac_cnt_t   npair_reg;
    rate_t      fac_reg;
    logic       job_last_reg;
    sample_t    a_reg;
    sample_t    b_reg;
    sample_t    step_reg;
    sample_t    mid_reg;

    // Output register
    logic       out_valid_reg;
    sample_t    out_sample_reg;
    logic       out_run_last_reg;
    logic       out_done_reg;

    logic       in_acc;
    logic       out_load;
    logic       job_end;
    rate_t      fac_now;
    fac_cnt_t   fac_cnt;
    fac_cnt_t   npair_next;
    fac_cnt_t   nhold_next;
    logic [3:0] ntot_next;
    sample_t    step_next;
    sample_t    mid_next;
    sample_t    res_sample;

    // Handshake
    assign out_load     = job_valid_reg && (!out_valid_reg || out_ch.ready);
    assign job_end      = out_load && (idx_reg == cnt_last_reg);
    assign in_ch.ready  = !job_valid_reg || job_end;
    assign in_acc       = in_ch.valid && in_ch.ready;

    // Decode rate mode; code 3 acts as passthrough
    always_comb
    begin
        unique case (rate_mode_reg)
            RATE_X2: begin fac_now = RATE_X2; fac_cnt = 3'd2; end
            RATE_X4: begin fac_now = RATE_X4; fac_cnt = 3'd4; end
            default: begin fac_now = RATE_X1; fac_cnt = 3'd1; end
        endcase
    end

    // Capture arithmetic: step (b-a)/4 and midpoint (a+b)/2, truncated toward zero
    always_comb
    begin
        logic signed [SAMPLE_W:0] diff;
        logic signed [SAMPLE_W:0] diff_adj;
        logic signed [SAMPLE_W:0] sum;
        logic signed [SAMPLE_W:0] sum_adj;
        logic signed [SAMPLE_W:0] step_w;
        logic signed [SAMPLE_W:0] mid_w;

        diff     = {in_ch.sample_in[SAMPLE_W-1], in_ch.sample_in}
                 - {held_sample_reg[SAMPLE_W-1], held_sample_reg};
        diff_adj = diff + (diff[SAMPLE_W] ? 17'sd3 : 17'sd0);
        step_w   = diff_adj >>> 2;
        sum      = {in_ch.sample_in[SAMPLE_W-1], in_ch.sample_in}
                 + {held_sample_reg[SAMPLE_W-1], held_sample_reg};
        sum_adj  = sum + (sum[SAMPLE_W] ? 17'sd1 : 17'sd0);
        mid_w    = sum_adj >>> 1;
        step_next = step_w[SAMPLE_W-1:0];
        mid_next  = mid_w[SAMPLE_W-1:0];

        npair_next = held_valid_reg ? fac_cnt : 3'd0;
        nhold_next = in_ch.frame_end ? fac_cnt : 3'd0;
        ntot_next  = {1'b0, npair_next} + {1'b0, nhold_next};
    end

    // Result for the current index: pair points first, then the hold run
    always_comb
    begin
        logic signed [SAMPLE_W:0] offs;
        logic signed [SAMPLE_W:0] pt;

        case (idx_reg[1:0])
            2'd1:    offs = {step_reg[SAMPLE_W-1], step_reg};
            2'd2:    offs = {step_reg, 1'b0};
            default: offs = {step_reg[SAMPLE_W-1], step_reg} + {step_reg, 1'b0};
        endcase
        pt = {a_reg[SAMPLE_W-1], a_reg} + offs;

        if (idx_reg >= npair_reg)
            res_sample = b_reg;
        else if (idx_reg == 3'd0)
            res_sample = a_reg;
        else if (fac_reg == RATE_X2)
            res_sample = mid_reg;
        else
            res_sample = pt[SAMPLE_W-1:0];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_mode_reg  <= RATE_X1;
            held_valid_reg <= 1'b0;
            job_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            cnt_last_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                rate_mode_reg <= cfg_wdata;

            if (in_acc)
                held_valid_reg <= !in_ch.frame_end;

            // job advance / reload
            if (in_acc)
            begin
                job_valid_reg <= (ntot_next != 4'd0);
                idx_reg       <= '0;
                cnt_last_reg  <= 3'(ntot_next - 4'd1);
            end
            else if (job_end)
                job_valid_reg <= 1'b0;
            else if (out_load)
                idx_reg <= idx_reg + 3'd1;

            // output register
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            held_sample_reg <= in_ch.sample_in;
            a_reg           <= held_sample_reg;
            b_reg           <= in_ch.sample_in;
            step_reg        <= step_next;
            mid_reg         <= mid_next;
            npair_reg       <= npair_next;
            fac_reg         <= fac_now;
            job_last_reg    <= in_ch.frame_end;
        end
        if (out_load)
        begin
            out_sample_reg   <= res_sample;
            out_run_last_reg <= (idx_reg == cnt_last_reg);
            out_done_reg     <= (idx_reg == cnt_last_reg) && job_last_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = out_sample_reg;
    assign out_ch.run_last   = out_run_last_reg;
    assign out_ch.frame_done = out_done_reg;

endmodule
